FILE: sv/u16u8_pkg.sv
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
package u16u8_pkg;

    // Input code unit width and the widened sum used when a surrogate pair is joined.
    localparam int unsigned UnitW = 21;
    localparam int unsigned SumW  = 22;

    // Surrogate ranges and plane limits.
    localparam logic [UnitW-1:0] HighFirst  = 21'h00D800;
    localparam logic [UnitW-1:0] HighLast   = 21'h00DBFF;
    localparam logic [SumW-1:0]  PairBias   = 22'h002400;  // 0x10000 - 0xDC00
    localparam logic [SumW-1:0]  MaxCode    = 22'h10FFFF;
    localparam logic [UnitW-1:0] Max1Byte   = 21'h00007F;
    localparam logic [UnitW-1:0] Max2Byte   = 21'h0007FF;
    localparam logic [UnitW-1:0] Max3Byte   = 21'h00FFFF;

    // UTF-8 lead and continuation markers.
    localparam logic [7:0] Lead2Byte = 8'hC0;
    localparam logic [7:0] Lead3Byte = 8'hE0;
    localparam logic [7:0] Lead4Byte = 8'hF0;
    localparam logic [7:0] ContByte  = 8'h80;

    // One encoded code point: up to four bytes, first byte in slot 0.
    typedef struct packed {
        logic [1:0]      last_idx;
        logic [3:0][7:0] bytes;
    } u16u8_entry_t;

    // Status from the front end.
    typedef struct packed {
        logic pending_valid;
    } u16u8_front_stat_t;

    // Status from the back end.
    typedef struct packed {
        logic mid_item;
    } u16u8_back_stat_t;

endpackage

FILE: sv/u16u8_front.sv
// Front end: accepts code units, tracks a held high surrogate and encodes to UTF-8.
module u16u8_front
    import u16u8_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [UnitW-1:0]  s_code_unit,
    input  logic              q_full,
    output logic              q_push,
    output u16u8_entry_t      q_entry,
    output u16u8_front_stat_t stat
);

    logic             pending_valid_reg, pending_valid_next;
    logic [9:0]       offset_reg, offset_next;
    logic             is_high;
    logic             accept;
    logic [SumW-1:0]  joined;
    logic [SumW-1:0]  value;
    logic             in_range;

    // Encode a code point that is known to be in range.
    function automatic u16u8_entry_t encode(input logic [UnitW-1:0] v);
        u16u8_entry_t e;
        e.bytes = '0;
        if (v <= Max1Byte) begin
            e.last_idx = 2'd0;
            e.bytes[0] = v[7:0];
        end else if (v <= Max2Byte) begin
            e.last_idx = 2'd1;
            e.bytes[0] = Lead2Byte | {3'b000, v[10:6]};
            e.bytes[1] = ContByte | {2'b00, v[5:0]};
        end else if (v <= Max3Byte) begin
            e.last_idx = 2'd2;
            e.bytes[0] = Lead3Byte | {4'b0000, v[15:12]};
            e.bytes[1] = ContByte | {2'b00, v[11:6]};
            e.bytes[2] = ContByte | {2'b00, v[5:0]};
        end else begin
            e.last_idx = 2'd3;
            e.bytes[0] = Lead4Byte | {5'b00000, v[20:18]};
            e.bytes[1] = ContByte | {2'b00, v[17:12]};
            e.bytes[2] = ContByte | {2'b00, v[11:6]};
            e.bytes[3] = ContByte | {2'b00, v[5:0]};
        end
        return e;
    endfunction

    // Classify the beat and form the code point, joining with a held offset.
    always_comb begin
        is_high  = (s_code_unit >= HighFirst) && (s_code_unit <= HighLast);
        joined   = {2'b00, offset_reg, 10'b0} + {1'b0, s_code_unit} + PairBias;
        value    = pending_valid_reg ? joined : {1'b0, s_code_unit};
        in_range = (value <= MaxCode);
        s_ready  = !q_full;
        accept   = s_valid && s_ready;
        q_push   = accept && !is_high && in_range;
        q_entry  = encode(value[UnitW-1:0]);
        stat.pending_valid = pending_valid_reg;
    end

    // A high surrogate is held; any other beat consumes and clears the hold.
    always_comb begin
        pending_valid_next = pending_valid_reg;
        offset_next        = offset_reg;
        if (accept) begin
            if (is_high) begin
                pending_valid_next = 1'b1;
                offset_next        = s_code_unit[9:0];
            end else begin
                pending_valid_next = 1'b0;
                offset_next        = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_valid_reg <= 1'b0;
            offset_reg        <= '0;
        end else begin
            pending_valid_reg <= pending_valid_next;
            offset_reg        <= offset_next;
        end
    end

endmodule

FILE: sv/u16u8_queue.sv
// Short first-in first-out queue of encoded code points between front and back.
module u16u8_queue
    import u16u8_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  u16u8_entry_t push_entry,
    input  logic         pop,
    output u16u8_entry_t head,
    output logic         empty,
    output logic         full
);

    localparam int unsigned PtrW = $clog2(DEPTH);
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    u16u8_entry_t    entries_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    // Pointer and fill-count updates.
    always_comb begin
        empty       = (count_reg == '0);
        full        = (count_reg == FullCnt);
        head        = entries_reg[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: sv/u16u8_back.sv
// Back end: walks the bytes of the queue head into a registered output beat.
module u16u8_back
    import u16u8_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  u16u8_entry_t     head,
    input  logic             q_empty,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_last_byte,
    output u16u8_back_stat_t stat
);

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic [1:0] idx_reg, idx_next;
    logic       load;
    logic       at_last;

    // Load the next byte whenever the queue is not empty and the output register is free or being drained.
    always_comb begin
        load       = !q_empty && (!valid_reg || m_ready);
        at_last    = (idx_reg == head.last_idx);
        q_pop      = load && at_last;
        valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);
        byte_next  = byte_reg;
        last_next  = last_reg;
        idx_next   = idx_reg;
        if (load) begin
            byte_next = head.bytes[idx_reg];
            last_next = at_last;
            idx_next  = at_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // Output payload needs no reset.
    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign m_valid       = valid_reg;
    assign m_out_byte    = byte_reg;
    assign m_last_byte   = last_reg;
    assign stat.mid_item = (idx_reg != 2'd0);

endmodule

FILE: sv/utf16_to_utf8_transcoder.sv
// The first UTF-8 byte of an accepted item is written to the queue and then loaded into
// the output register before it is shown. Throughput: the output port moves one byte per
// cycle while the queue is not empty and m_ready is high; the queue of QUEUE_DEPTH items
// lets input run ahead. High surrogates and out-of-range values are consumed on input and
// produce no bytes. Reset (aresetn, synchronous, active low) clears the held surrogate,
// the queue and the output valid flag, after which s_ready is high.
module utf16_to_utf8_transcoder
    import u16u8_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [UnitW-1:0] s_code_unit,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_last_byte
);

    u16u8_entry_t      push_entry;
    u16u8_entry_t      head;
    logic              q_push;
    logic              q_pop;
    logic              q_empty;
    logic              q_full;
    u16u8_front_stat_t front_stat;
    u16u8_back_stat_t  back_stat;

    // Classification, surrogate joining and encoding.
    u16u8_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_code_unit (s_code_unit),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (push_entry),
        .stat        (front_stat)
    );

    // Decoupling queue.
    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head       (head),
        .empty      (q_empty),
        .full       (q_full)
    );

    // Byte serializer with output register.
    u16u8_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (head),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_last_byte (m_last_byte),
        .stat        (back_stat)
    );

    // An accepted high surrogate is held for the next beat.
    a_high_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_code_unit >= HighFirst) && (s_code_unit <= HighLast))
        |=> front_stat.pending_valid)
        else $error("high surrogate was not held");

    // The serializer is only part way through an item while that item sits in the queue.
    a_mid_item_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        back_stat.mid_item |-> !q_empty)
        else $error("serializer mid item with empty queue");

    // A non-final byte taken is always followed at once by the next byte of that item.
    a_item_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_byte) |=> m_valid)
        else $error("gap inside an encoded item");

endmodule
